// File: sv/ptsched_pkg.sv
// Process table scheduler: shared constants, codes and types.
// Used by the channel interfaces and the top level; no dependencies.
package ptsched_pkg;

  localparam int MAX_PROCS = 16;
  localparam int PC_BITS   = 16;
  localparam int ID_W      = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int QA_W      = ID_W + 2;
  localparam int QDEPTH    = 3 << ID_W;

  localparam int OP_W   = 3;
  localparam int PID_W  = 4;
  localparam int CODE_W = 16;
  localparam int RSN_W  = 2;
  localparam int NPC_W  = 16;
  localparam int ST_W   = 3;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 5;

  localparam logic [OP_W-1:0] OP_CREATE   = 3'd0;
  localparam logic [OP_W-1:0] OP_DISPATCH = 3'd1;
  localparam logic [OP_W-1:0] OP_COMPLETE = 3'd2;
  localparam logic [OP_W-1:0] OP_EVENT    = 3'd3;
  localparam logic [OP_W-1:0] OP_KILL     = 3'd4;
  localparam logic [OP_W-1:0] OP_RELEASE  = 3'd5;

  localparam logic [ST_W-1:0] ST_UNALLOC = 3'd0;
  localparam logic [ST_W-1:0] ST_READY   = 3'd1;
  localparam logic [ST_W-1:0] ST_RUNNING = 3'd2;
  localparam logic [ST_W-1:0] ST_BLOCKED = 3'd3;
  localparam logic [ST_W-1:0] ST_TERM    = 3'd4;

  localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOFREE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_SKIP   = 2'd3;

  localparam logic [RSN_W-1:0] RSN_TERM  = 2'd0;
  localparam logic [RSN_W-1:0] RSN_SLICE = 2'd1;
  localparam logic [RSN_W-1:0] RSN_BLOCK = 2'd2;

  localparam logic [1:0] Q_FREE    = 2'd0;
  localparam logic [1:0] Q_READY   = 2'd1;
  localparam logic [1:0] Q_BLOCKED = 2'd2;

  typedef struct packed {
    logic [ST_W-1:0]    state;
    logic [CODE_W-1:0]  code;
    logic [PC_BITS-1:0] pc;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_EXEC
  } fsm_t;

endpackage

// File: sv/ptsched_if.sv
// Request and result channel interfaces of the process table scheduler.
// Depends on ptsched_pkg for field widths.
interface ptsched_req_if import ptsched_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [PID_W-1:0]  proc_id;
  logic [CODE_W-1:0] code_handle;
  logic [RSN_W-1:0]  finish_reason;
  logic [NPC_W-1:0]  new_pc;

  modport source (output valid, operation, proc_id, code_handle, finish_reason, new_pc,
                  input ready);
  modport sink   (input valid, operation, proc_id, code_handle, finish_reason, new_pc,
                  output ready);
endinterface

interface ptsched_rsp_if import ptsched_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [PID_W-1:0]  result_id;
  logic [CODE_W-1:0] result_code;
  logic [CODE_W-1:0] result_pc;
  logic [ST_W-1:0]   entry_state;
  logic [STAT_W-1:0] status;

  modport source (output valid, ok, result_id, result_code, result_pc, entry_state, status,
                  input ready);
  modport sink   (input valid, ok, result_id, result_code, result_pc, entry_state, status,
                  output ready);
endinterface

// File: sv/process_table_scheduler_top.sv
// Process table scheduler top level: process table and three ID FIFOs in memories.
// Depends on ptsched_pkg and the channel interfaces in ptsched_if.sv.
//
// Complete, kill, release and unknown codes read the table at accept, then reach the
// result register from execute; create, dispatch and event read their FIFO at accept,
// then the table in the pop state, then reach execute, or go straight to execute with
// no table read when their FIFO is empty. One request is in work at a time: a new one
// is taken only in idle; a held result stalls the next request in execute.
// Reset and a cfg write clear the table valid bits and refill the free FIFO at once.
module process_table_scheduler_top import ptsched_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  ptsched_req_if.sink       in_ch,
  ptsched_rsp_if.source     out_ch,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  function automatic logic [CNT_W-1:0] sat_count(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] n;
    if (v == '0) begin
      n = CNT_W'(1);
    end else if (int'(v) > MAX_PROCS) begin
      n = CNT_W'(MAX_PROCS);
    end else begin
      n = CNT_W'(v);
    end
    return n;
  endfunction

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  fsm_t state_r, state_nxt;

  // captured request
  logic [OP_W-1:0]   op_r;
  logic [PID_W-1:0]  pid_r;
  logic [CODE_W-1:0] code_r;
  logic [RSN_W-1:0]  rsn_r;
  logic [NPC_W-1:0]  npc_r;
  logic              empty_r;

  // FIFO pointers
  logic [ID_W-1:0]  head_r [3];
  logic [CNT_W-1:0] cnt_r  [3];
  logic [MAX_PROCS-1:0] fslot_vld_r;
  logic [MAX_PROCS-1:0] ent_vld_r;

  // memories
  logic [ID_W-1:0] qmem [QDEPTH];
  entry_t          tmem [MAX_PROCS];
  logic [ID_W-1:0] qrd_r;
  logic            qforce_r;
  logic [ID_W-1:0] qslot_r;
  entry_t          trd_r;
  logic            tvld_r;

  // result register
  logic              out_valid_r;
  logic              ok_r;
  logic [PID_W-1:0]  rid_r;
  logic [CODE_W-1:0] rcode_r;
  logic [CODE_W-1:0] rpc_r;
  logic [ST_W-1:0]   rst_r;
  logic [STAT_W-1:0] stat_r;

  logic acc, exec_go, is_pop_op, pop_go;
  logic [1:0]       pop_q;
  logic [ID_W-1:0]  sel_head;
  logic [CNT_W-1:0] sel_cnt;
  logic [ID_W-1:0]  fid;

  logic             trd_en;
  logic [ID_W-1:0]  trd_addr;

  // execute-stage results
  logic              x_ok;
  logic [PID_W-1:0]  x_rid;
  logic [CODE_W-1:0] x_rcode;
  logic [CODE_W-1:0] x_rpc;
  logic [ST_W-1:0]   x_rst;
  logic [STAT_W-1:0] x_stat;
  logic              tw_en;
  logic [ID_W-1:0]   tw_addr;
  entry_t            tw_data;
  logic              push_en;
  logic [1:0]        push_q;
  logic [ID_W-1:0]   push_id;

  logic [ST_W-1:0]    cur_st;
  logic [PC_BITS-1:0] cur_pc;
  logic               pid_ok;
  logic [ID_W-1:0]    pid_idx;
  logic [ST_W-1:0]    want_st;

  logic [ID_W-1:0]  ph_head;
  logic [CNT_W-1:0] ph_cnt;
  logic [CNT_W:0]   tail_sum;
  logic [ID_W-1:0]  tail;
  logic             push_go;

  assign acc     = in_ch.valid && in_ch.ready;
  assign exec_go = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);

  always_comb begin
    pop_q     = Q_FREE;
    is_pop_op = 1'b0;
    case (in_ch.operation)
      OP_CREATE: begin
        pop_q     = Q_FREE;
        is_pop_op = 1'b1;
      end
      OP_DISPATCH: begin
        pop_q     = Q_READY;
        is_pop_op = 1'b1;
      end
      OP_EVENT: begin
        pop_q     = Q_BLOCKED;
        is_pop_op = 1'b1;
      end
      default: begin
        pop_q     = Q_FREE;
        is_pop_op = 1'b0;
      end
    endcase
  end

  always_comb begin
    sel_head = '0;
    sel_cnt  = '0;
    ph_head  = '0;
    ph_cnt   = '0;
    for (int q = 0; q < 3; q++) begin
      if (pop_q == 2'(q)) begin
        sel_head = head_r[q];
        sel_cnt  = cnt_r[q];
      end
      if (push_q == 2'(q)) begin
        ph_head = head_r[q];
        ph_cnt  = cnt_r[q];
      end
    end
  end

  assign pop_go = acc && is_pop_op && (sel_cnt != '0);

  // push slot: (head + count) wrapped at the FIFO depth
  always_comb begin
    tail_sum = (CNT_W + 1)'(ph_head) + (CNT_W + 1)'(ph_cnt);
    if (int'(tail_sum) >= MAX_PROCS) begin
      tail = ID_W'(int'(tail_sum) - MAX_PROCS);
    end else begin
      tail = ID_W'(tail_sum);
    end
  end

  assign push_go = exec_go && push_en && (int'(ph_cnt) < MAX_PROCS);

  // free-FIFO slots never written since init read as their own index
  assign fid = qforce_r ? qslot_r : qrd_r;

  // FSM
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          state_nxt = pop_go ? S_POP : S_EXEC;
        end
      end
      S_POP: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    trd_en      = 1'b0;
    trd_addr    = fid;
    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        trd_en      = acc && !is_pop_op;
        trd_addr    = ID_W'(in_ch.proc_id);
      end
      S_POP: begin
        trd_en   = 1'b1;
        trd_addr = fid;
      end
      default: begin
        in_ch.ready = 1'b0;
        trd_en      = 1'b0;
        trd_addr    = fid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (acc) begin
      op_r    <= in_ch.operation;
      pid_r   <= in_ch.proc_id;
      code_r  <= in_ch.code_handle;
      rsn_r   <= in_ch.finish_reason;
      npc_r   <= in_ch.new_pc;
      empty_r <= (sel_cnt == '0);
    end
  end

  // FIFO memory: pop read at accept, push write at execute
  always_ff @(posedge clk) begin
    if (pop_go) begin
      qrd_r    <= qmem[{pop_q, sel_head}];
      qforce_r <= (pop_q == Q_FREE) && !fslot_vld_r[sel_head];
      qslot_r  <= sel_head;
    end
    if (push_go) begin
      qmem[{push_q, tail}] <= push_id;
    end
  end

  // process table memory
  always_ff @(posedge clk) begin
    if (trd_en) begin
      trd_r  <= tmem[trd_addr];
      tvld_r <= ent_vld_r[trd_addr];
    end
    if (exec_go && tw_en) begin
      tmem[tw_addr] <= tw_data;
    end
  end

  // pointers and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      for (int q = 0; q < 3; q++) begin
        head_r[q] <= '0;
        cnt_r[q]  <= '0;
      end
      cnt_r[Q_FREE] <= sat_count(rst_n ? cfg_wdata : CFG_RESET);
      fslot_vld_r   <= '0;
      ent_vld_r     <= '0;
    end else begin
      for (int q = 0; q < 3; q++) begin
        if (pop_go && pop_q == 2'(q)) begin
          head_r[q] <= (int'(head_r[q]) == MAX_PROCS - 1) ? '0 : head_r[q] + 1'b1;
          cnt_r[q]  <= cnt_r[q] - 1'b1;
        end
        if (push_go && push_q == 2'(q)) begin
          cnt_r[q] <= cnt_r[q] + 1'b1;
        end
      end
      if (push_go && push_q == Q_FREE) begin
        fslot_vld_r[tail] <= 1'b1;
      end
      if (exec_go && tw_en) begin
        ent_vld_r[tw_addr] <= 1'b1;
      end
    end
  end

  // execute: decide on the entry, its new contents and any push
  assign cur_st  = tvld_r ? trd_r.state : ST_UNALLOC;
  assign cur_pc  = tvld_r ? trd_r.pc : '0;
  assign pid_ok  = int'(pid_r) < MAX_PROCS;
  assign pid_idx = ID_W'(pid_r);
  assign want_st = (op_r == OP_DISPATCH) ? ST_READY : ST_BLOCKED;

  always_comb begin
    x_ok    = 1'b0;
    x_rid   = '0;
    x_rcode = '0;
    x_rpc   = '0;
    x_rst   = ST_UNALLOC;
    x_stat  = STAT_SKIP;
    tw_en   = 1'b0;
    tw_addr = pid_idx;
    tw_data = '{state: cur_st, code: trd_r.code, pc: cur_pc};
    push_en = 1'b0;
    push_q  = Q_READY;
    push_id = pid_idx;
    case (op_r)
      OP_CREATE: begin
        if (empty_r) begin
          x_stat = STAT_NOFREE;
        end else begin
          tw_en   = 1'b1;
          tw_addr = fid;
          tw_data = '{state: ST_READY, code: code_r, pc: '0};
          push_en = 1'b1;
          push_q  = Q_READY;
          push_id = fid;
          x_ok    = 1'b1;
          x_stat  = STAT_DONE;
          x_rid   = PID_W'(fid);
          x_rcode = code_r;
          x_rst   = ST_READY;
        end
      end
      OP_DISPATCH, OP_EVENT: begin
        if (empty_r) begin
          x_stat = STAT_EMPTY;
        end else begin
          x_rid   = PID_W'(fid);
          tw_addr = fid;
          push_id = fid;
          if (cur_st != want_st) begin
            // stale ID: dropped
            x_rst = cur_st;
          end else if (op_r == OP_DISPATCH) begin
            tw_en         = 1'b1;
            tw_data.state = ST_RUNNING;
            x_rcode       = trd_r.code;
            x_rpc         = CODE_W'(cur_pc);
            x_rst         = ST_RUNNING;
            x_ok          = 1'b1;
            x_stat        = STAT_DONE;
          end else begin
            tw_en         = 1'b1;
            tw_data.state = ST_READY;
            push_en       = 1'b1;
            push_q        = Q_READY;
            x_rst         = ST_READY;
            x_ok          = 1'b1;
            x_stat        = STAT_DONE;
          end
        end
      end
      OP_COMPLETE: begin
        x_rid = pid_r;
        if (pid_ok) begin
          x_rst = cur_st;
          if (cur_st == ST_RUNNING && rsn_r <= RSN_BLOCK) begin
            tw_en      = 1'b1;
            tw_data.pc = PC_BITS'(npc_r);
            x_ok       = 1'b1;
            x_stat     = STAT_DONE;
            case (rsn_r)
              RSN_TERM: begin
                tw_data.state = ST_TERM;
              end
              RSN_SLICE: begin
                tw_data.state = ST_READY;
                push_en       = 1'b1;
                push_q        = Q_READY;
              end
              default: begin
                tw_data.state = ST_BLOCKED;
                push_en       = 1'b1;
                push_q        = Q_BLOCKED;
              end
            endcase
            x_rst = tw_data.state;
          end
        end
      end
      OP_KILL: begin
        x_rid = pid_r;
        if (pid_ok) begin
          x_rst = cur_st;
          if (cur_st != ST_UNALLOC && cur_st != ST_TERM) begin
            tw_en         = 1'b1;
            tw_data.state = ST_TERM;
            x_rst         = ST_TERM;
            x_ok          = 1'b1;
            x_stat        = STAT_DONE;
          end
        end
      end
      OP_RELEASE: begin
        x_rid = pid_r;
        if (pid_ok) begin
          x_rst = cur_st;
          if (cur_st == ST_TERM) begin
            tw_en         = 1'b1;
            tw_data.state = ST_UNALLOC;
            push_en       = 1'b1;
            push_q        = Q_FREE;
            x_rst         = ST_UNALLOC;
            x_ok          = 1'b1;
            x_stat        = STAT_DONE;
          end
        end
      end
      default: begin
        x_stat = STAT_SKIP;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      ok_r    <= x_ok;
      rid_r   <= x_rid;
      rcode_r <= x_rcode;
      rpc_r   <= x_rpc;
      rst_r   <= x_rst;
      stat_r  <= x_stat;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.ok          = ok_r;
  assign out_ch.result_id   = rid_r;
  assign out_ch.result_code = rcode_r;
  assign out_ch.result_pc   = rpc_r;
  assign out_ch.entry_state = rst_r;
  assign out_ch.status      = stat_r;

endmodule

// File: tb/process_table_scheduler_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for process_table_scheduler_top: random and directed requests,
// a scoreboard class that predicts every result. Depends on ptsched_pkg and ptsched_if.sv.
module process_table_scheduler_top_test;
  import ptsched_pkg::*;

  localparam logic [OP_W-1:0]  OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0]  OP_UNUSED_HI = 3'd7;
  localparam logic [RSN_W-1:0] RSN_BAD      = 2'd3;
  localparam int ITEMS_PER_PHASE = 232;
  localparam int NUM_PHASES      = 8;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [PID_W-1:0]  pid;
    logic [CODE_W-1:0] code;
    logic [RSN_W-1:0]  reason;
    logic [NPC_W-1:0]  npc;
  } sched_req_t;

  typedef struct packed {
    logic              ok;
    logic [PID_W-1:0]  id;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] pc;
    logic [ST_W-1:0]   state;
    logic [STAT_W-1:0] status;
  } sched_rsp_t;

  class sched_scoreboard;
    logic [ST_W-1:0]    state_tab[MAX_PROCS];
    logic [CODE_W-1:0]  code_tab[MAX_PROCS];
    logic [PC_BITS-1:0] pc_tab[MAX_PROCS];
    logic [ID_W-1:0]    fifo[3][$];
    sched_rsp_t         expected[$];
    int                 errors;

    function new();
      errors = 0;
      load_pool(CFG_W'(MAX_PROCS));
    endfunction

    // Register write rebuilds the whole table; count saturates to 1..MAX_PROCS.
    function void load_pool(logic [CFG_W-1:0] v);
      int n;
      n = int'(v);
      if (n < 1) n = 1;
      if (n > MAX_PROCS) n = MAX_PROCS;
      for (int i = 0; i < MAX_PROCS; i++) begin
        state_tab[i] = ST_UNALLOC;
        code_tab[i]  = '0;
        pc_tab[i]    = '0;
      end
      for (int q = 0; q < 3; q++) fifo[q].delete();
      for (int i = 0; i < n; i++) fifo[Q_FREE].push_back(ID_W'(i));
    endfunction

    // Full FIFO drops the ID; only stale duplicates get here.
    function void push_id(logic [1:0] q, logic [ID_W-1:0] id);
      if (fifo[q].size() < MAX_PROCS) fifo[q].push_back(id);
    endfunction

    function bit pick_id(logic [ST_W-1:0] s, output logic [ID_W-1:0] id);
      logic [ID_W-1:0] hits[$];
      id = '0;
      for (int i = 0; i < MAX_PROCS; i++)
        if (state_tab[i] == s) hits.push_back(ID_W'(i));
      if (hits.size() == 0) return 0;
      id = hits[$urandom_range(hits.size() - 1)];
      return 1;
    endfunction

    function sched_rsp_t schedule_step(sched_req_t r);
      sched_rsp_t      e;
      logic [ID_W-1:0] id;
      logic [1:0]      qi;
      logic [ST_W-1:0] want;
      bit              applied;
      e = '0;
      e.status = STAT_SKIP;
      applied = 0;
      case (r.op)
        OP_CREATE: begin
          if (fifo[Q_FREE].size() == 0) begin
            e.status = STAT_NOFREE;
          end else begin
            id = fifo[Q_FREE].pop_front();
            code_tab[id]  = r.code;
            pc_tab[id]    = '0;
            state_tab[id] = ST_READY;
            push_id(Q_READY, id);
            e.ok = 1'b1; e.status = STAT_DONE; e.id = id;
            e.code = r.code; e.state = ST_READY;
          end
        end
        OP_DISPATCH, OP_EVENT: begin
          qi   = (r.op == OP_DISPATCH) ? Q_READY : Q_BLOCKED;
          want = (r.op == OP_DISPATCH) ? ST_READY : ST_BLOCKED;
          if (fifo[qi].size() == 0) begin
            e.status = STAT_EMPTY;
          end else begin
            id = fifo[qi].pop_front();
            e.id = id;
            if (state_tab[id] != want) begin
              // stale entry: dropped, current state reported
              e.state = state_tab[id];
            end else begin
              if (r.op == OP_DISPATCH) begin
                state_tab[id] = ST_RUNNING;
                e.code = code_tab[id];
                e.pc   = CODE_W'(pc_tab[id]);
              end else begin
                state_tab[id] = ST_READY;
                push_id(Q_READY, id);
              end
              e.ok = 1'b1; e.status = STAT_DONE; e.state = state_tab[id];
            end
          end
        end
        OP_COMPLETE, OP_KILL, OP_RELEASE: begin
          e.id = r.pid;
          e.state = state_tab[r.pid];
          if (r.op == OP_COMPLETE) begin
            if (e.state == ST_RUNNING && r.reason != RSN_BAD) begin
              pc_tab[r.pid] = r.npc[PC_BITS-1:0];
              if (r.reason == RSN_TERM) begin
                state_tab[r.pid] = ST_TERM;
              end else if (r.reason == RSN_SLICE) begin
                state_tab[r.pid] = ST_READY;
                push_id(Q_READY, r.pid);
              end else begin
                state_tab[r.pid] = ST_BLOCKED;
                push_id(Q_BLOCKED, r.pid);
              end
              applied = 1;
            end
          end else if (r.op == OP_KILL) begin
            if (e.state != ST_UNALLOC && e.state != ST_TERM) begin
              state_tab[r.pid] = ST_TERM;
              applied = 1;
            end
          end else if (e.state == ST_TERM) begin
            state_tab[r.pid] = ST_UNALLOC;
            push_id(Q_FREE, r.pid);
            applied = 1;
          end
          if (applied) begin
            e.ok = 1'b1; e.status = STAT_DONE; e.state = state_tab[r.pid];
          end
        end
        default: ;
      endcase
      return e;
    endfunction

    function void note_request(sched_req_t r);
      expected.push_back(schedule_step(r));
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    endfunction

    function void check_result(sched_rsp_t got);
      sched_rsp_t want;
      if (expected.size() == 0) begin
        errors++;
        if (errors <= 40) $display("%0t: result with no request outstanding", $time);
        return;
      end
      want = expected.pop_front();
      if (got.ok !== want.ok)
        report("ok", 32'(want.ok), 32'(got.ok));
      if (got.id !== want.id)
        report("result_id", 32'(want.id), 32'(got.id));
      if (got.code !== want.code)
        report("result_code", 32'(want.code), 32'(got.code));
      if (got.pc !== want.pc)
        report("result_pc", 32'(want.pc), 32'(got.pc));
      if (got.state !== want.state)
        report("entry_state", 32'(want.state), 32'(got.state));
      if (got.status !== want.status)
        report("status", 32'(want.status), 32'(got.status));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  bit               steady = 1'b0;
  sched_scoreboard  sb = new();

  ptsched_req_if req_ch();
  ptsched_rsp_if rsp_ch();

  process_table_scheduler_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    rsp_ch.ready <= steady || ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready)
      sb.check_result('{rsp_ch.ok, rsp_ch.result_id, rsp_ch.result_code, rsp_ch.result_pc,
                        rsp_ch.entry_state, rsp_ch.status});
  end

  function automatic sched_req_t mk(logic [OP_W-1:0] op, logic [PID_W-1:0] pid,
                                    logic [CODE_W-1:0] code, logic [RSN_W-1:0] reason,
                                    logic [NPC_W-1:0] npc);
    sched_req_t r;
    r = '{op, pid, code, reason, npc};
    return r;
  endfunction

  // Mostly well-formed: IDs for complete/kill/release are picked from entries
  // in the state the operation needs; the rest is noise.
  function automatic sched_req_t random_request();
    sched_req_t      r;
    int unsigned     roll;
    logic [ID_W-1:0] id;
    logic [ST_W-1:0] want;
    want     = ST_TERM;
    r.op     = OP_CREATE;
    r.pid    = PID_W'($urandom);
    r.code   = CODE_W'($urandom);
    r.reason = RSN_W'($urandom_range(2));
    r.npc    = NPC_W'($urandom);
    if ($urandom_range(9) == 0) r.code = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    if ($urandom_range(9) == 0) r.npc = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    roll = $urandom_range(99);
    if (roll < 20) begin
      r.op = OP_CREATE;
    end else if (roll < 42) begin
      r.op = OP_DISPATCH;
    end else if (roll < 66) begin
      r.op = OP_COMPLETE;
      want = ST_RUNNING;
      if ($urandom_range(19) == 0) r.reason = RSN_BAD;
    end else if (roll < 76) begin
      r.op = OP_EVENT;
    end else if (roll < 85) begin
      r.op = OP_KILL;
      roll = $urandom_range(2);
      want = (roll == 0) ? ST_READY : (roll == 1) ? ST_RUNNING : ST_BLOCKED;
    end else if (roll < 97) begin
      r.op = OP_RELEASE;
    end else begin
      r.op = $urandom_range(1) ? OP_UNUSED_HI : OP_UNUSED_LO;
    end
    if ((r.op == OP_COMPLETE || r.op == OP_KILL || r.op == OP_RELEASE) &&
        $urandom_range(99) < 85 && sb.pick_id(want, id))
      r.pid = id;
    return r;
  endfunction

  // Leaves valid high after the accept; callers that pause lower it first.
  task automatic send_request(sched_req_t r);
    while (!steady && $urandom_range(99) < 31) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.operation     <= r.op;
    req_ch.proc_id       <= r.pid;
    req_ch.code_handle   <= r.code;
    req_ch.finish_reason <= r.reason;
    req_ch.new_pc        <= r.npc;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(r);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_pool_size(logic [CFG_W-1:0] v);
    drain();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.load_pool(v);
  endtask

  initial begin
    #5_000_000;
    $display("process_table_scheduler_top regression: fail");
    $finish;
  end

  initial begin
    sched_req_t       directed[$];
    sched_req_t       r;
    logic [CFG_W-1:0] plan[NUM_PHASES];
    int               sent;
    req_ch.valid         <= 1'b0;
    req_ch.operation     <= '0;
    req_ch.proc_id       <= '0;
    req_ch.code_handle   <= '0;
    req_ch.finish_reason <= '0;
    req_ch.new_pc        <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queues, full life cycle, stale pops, wrong states, unused opcodes
    directed = '{
      mk(OP_DISPATCH, 0, 0, RSN_TERM, 0),
      mk(OP_EVENT, 0, 0, RSN_TERM, 0),
      mk(OP_CREATE, 0, 16'hFFFF, RSN_TERM, 0),
      mk(OP_CREATE, 0, 16'h0000, RSN_TERM, 0),
      mk(OP_COMPLETE, 0, 0, RSN_SLICE, 16'h5555),
      mk(OP_DISPATCH, 0, 0, RSN_TERM, 0),
      mk(OP_COMPLETE, 0, 0, RSN_BAD, 16'hFFFF),
      mk(OP_COMPLETE, 0, 0, RSN_BLOCK, 16'hFFFF),
      mk(OP_DISPATCH, 0, 0, RSN_TERM, 0),
      mk(OP_COMPLETE, 1, 0, RSN_SLICE, 16'h1234),
      mk(OP_EVENT, 0, 0, RSN_TERM, 0),
      mk(OP_KILL, 1, 0, RSN_TERM, 0),
      mk(OP_DISPATCH, 0, 0, RSN_TERM, 0),
      mk(OP_DISPATCH, 0, 0, RSN_TERM, 0),
      mk(OP_COMPLETE, 0, 0, RSN_TERM, 16'h0000),
      mk(OP_RELEASE, 0, 0, RSN_TERM, 0),
      mk(OP_RELEASE, 0, 0, RSN_TERM, 0),
      mk(OP_KILL, 15, 0, RSN_TERM, 0),
      mk(OP_UNUSED_LO, 15, 16'hFFFF, RSN_BAD, 16'hFFFF),
      mk(OP_UNUSED_HI, 15, 16'hFFFF, RSN_BAD, 16'hFFFF),
      mk(OP_CREATE, 0, 16'hABCD, RSN_TERM, 0),
      mk(OP_DISPATCH, 0, 0, RSN_TERM, 0),
      mk(OP_COMPLETE, 2, 0, RSN_BLOCK, 16'h8000),
      mk(OP_KILL, 2, 0, RSN_TERM, 0),
      mk(OP_EVENT, 0, 0, RSN_TERM, 0)
    };
    foreach (directed[i]) send_request(directed[i]);

    plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, CFG_W'($urandom_range(1, 16)),
             CFG_W'($urandom_range(17, 30)), 5'd8};
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_pool_size(plan[p]);
      steady = (p == 3);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if (p == 1 && sent == 100) drain();
        r = random_request();
        send_request(r);
        if (r.op <= OP_RELEASE) sent++;
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("process_table_scheduler_top regression: pass");
    end else begin
      $display("process_table_scheduler_top regression: fail");
    end
    $finish;
  end

endmodule
